FILE: hdl/phr_pkg.sv
// ============================================================================
// phr_pkg
// Shared constants, codes, types and the exp table ratio function of the
// point heatmap rasterizer.
// ============================================================================
package phr_pkg;

    // default geometry and table size
    localparam int MAX_HEIGHT_DEF      = 256;
    localparam int MAX_WIDTH_DEF       = 256;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    // fixed field widths
    localparam int COORD_W = 16;
    localparam int SRC_W   = 13;
    localparam int TGT_W   = 9;
    localparam int SIGMA_W = 8;
    localparam int PIX_W   = 16;
    localparam int CFG_W   = 13;
    localparam int CFGI_W  = 3;
    // distance inside a window stays below 48 * 255 + 256
    localparam int DX_W    = 14;
    // divisor of the table index: sigma^2 << 13
    localparam int DEN_W   = 2 * SIGMA_W + 13;

    // operation codes
    localparam logic [1:0] OP_PLACE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFGI_W-1:0] CFG_SRC_W  = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_SRC_H  = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_TGT_W  = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_TGT_H  = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_MODE   = 3'd4;
    localparam logic [CFGI_W-1:0] CFG_SIGMA  = 3'd5;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // quotient of a 64-bit value by a small divisor, shift and subtract
    function automatic logic [63:0] div_small(input logic [63:0] num,
                                              input logic [5:0] den);
        logic [63:0] quo;
        logic [6:0]  rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[5:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-step) in Q0.32 by a Taylor series, step given in Q.32
    function automatic logic [31:0] exp_ratio(input logic [63:0] step);
        logic [63:0] term;
        logic [63:0] acc;
        term = 64'h1_0000_0000;
        acc  = term;
        for (int n = 1; n < 64; n++) begin
            if (term != 64'd0) begin
                term = div_small((term * step) >> 32, 6'(n));
                if (n[0]) acc = acc - term;
                else acc = acc + term;
            end
        end
        return acc[31:0];
    endfunction

endpackage

FILE: hdl/phr_ram.sv
// ============================================================================
// phr_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module phr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/phr_div.sv
// ============================================================================
// phr_div
// Shared restoring divider, one quotient bit per cycle.
// ============================================================================
module phr_div
    import phr_pkg::*;
#(
    parameter int NUM_W = 39,
    parameter int D_W   = 29
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [D_W-1:0]   i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [D_W:0]     rem_sh;
    logic [D_W:0]     rem_sub;
    logic             ge;

    // one restoring step
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_num;

endmodule

FILE: hdl/phr_exp.sv
// ============================================================================
// phr_exp
// Exp table in RAM, filled after reset by repeated multiplication by
// exp(-16 / depth), then read one entry at a time.
// ============================================================================
module phr_exp
    import phr_pkg::*;
#(
    parameter int DEPTH = EXP_TABLE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    output logic                     o_busy,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [PIX_W-1:0]         o_rdata
);

    localparam int          ELW      = $clog2(DEPTH);
    localparam logic [63:0] EXP_STEP = (64'd16 << 32) / DEPTH;
    localparam logic [31:0] RATIO    = exp_ratio(EXP_STEP);

    logic              r_busy;
    logic [ELW-1:0]    r_idx;
    logic [31:0]       r_cur;
    logic [63:0]       prod;
    logic [32:0]       rnd;
    logic [PIX_W-1:0]  wval;

    // next power and rounded entry
    assign prod = r_cur * RATIO;
    assign rnd  = {1'b0, r_cur} + 33'd32768;
    always_comb begin
        if (r_idx == '0 || rnd[32]) wval = '1;
        else wval = rnd[31:16];
    end

    // fill sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_cur  <= RATIO;
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx != '0) r_cur <= prod[63:32];
            if (r_idx == ELW'(DEPTH - 1)) r_busy <= 1'b0;
        end
    end

    phr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_busy),
        .i_waddr (r_idx),
        .i_wdata (wval),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (o_rdata)
    );

    assign o_busy = r_busy;

endmodule

FILE: hdl/point_heatmap_rasterizer_top.sv
// Read: registered store read, then output register. Clear: one store entry per cycle.
// Binary place: two scaling divisions, x then y, then a single write of the pixel.
// Heatmap place: as binary, then one index division per window pixel (up to 98 x 98)
// on the shared one-bit-per-cycle divider; its width NW is 39 at default size.
// Reset runs a clearing pass over all MAX_HEIGHT * MAX_WIDTH store entries and fills
// the EXP_TABLE_DEPTH entries of the exp table; no beat is taken until both finish.
// ============================================================================
// point_heatmap_rasterizer_top
// Keeps one heatmap channel; places points as pixels or Gaussian splats,
// reads single pixels and clears the store.
// ============================================================================
module point_heatmap_rasterizer_top
    import phr_pkg::*;
#(
    parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFGI_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [COORD_W-1:0] i_point_x_q4,
    input  logic [COORD_W-1:0] i_point_y_q4,
    input  logic [7:0]         i_read_row,
    input  logic [7:0]         i_read_col,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_pixel_value
);

    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int TWW     = $clog2(MAX_WIDTH + 1);
    localparam int THW     = $clog2(MAX_HEIGHT + 1);
    localparam int CW      = (TWW > THW) ? TWW : THW;
    localparam int SX_W    = 20 + CW;
    localparam int LO_W    = SX_W - 8;
    localparam int HI_W    = SX_W - 7;
    localparam int SS_W    = SX_W + 1;
    localparam int STORE_D = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW      = $clog2(STORE_D);
    localparam int ELW     = $clog2(EXP_TABLE_DEPTH);
    localparam int DEW     = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int SUM_W   = 2 * DX_W + 1;
    localparam int SNUM_W  = SX_W + 1;
    localparam int INUM_W  = SUM_W + DEW + 1;
    localparam int NW      = (SNUM_W > INUM_W) ? SNUM_W : INUM_W;

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_SCX   = 4'd3;
    localparam logic [3:0] S_SCX_W = 4'd4;
    localparam logic [3:0] S_SCY   = 4'd5;
    localparam logic [3:0] S_SCY_W = 4'd6;
    localparam logic [3:0] S_BIN   = 4'd7;
    localparam logic [3:0] S_WIN   = 4'd8;
    localparam logic [3:0] S_PIX_A = 4'd9;
    localparam logic [3:0] S_PIX_B = 4'd10;
    localparam logic [3:0] S_PIX_W = 4'd11;
    localparam logic [3:0] S_PIX_C = 4'd12;

    // configuration
    logic [SRC_W-1:0]   r_src_w, r_src_h;
    logic [TGT_W-1:0]   r_tgt_w, r_tgt_h;
    logic               r_mode;
    logic [SIGMA_W-1:0] r_sigma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_W'(256);
            r_src_h <= SRC_W'(256);
            r_tgt_w <= TGT_W'(256);
            r_tgt_h <= TGT_W'(256);
            r_mode  <= 1'b0;
            r_sigma <= SIGMA_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_W: r_src_w <= i_cfg_data[SRC_W-1:0];
                CFG_SRC_H: r_src_h <= i_cfg_data[SRC_W-1:0];
                CFG_TGT_W: r_tgt_w <= i_cfg_data[TGT_W-1:0];
                CFG_TGT_H: r_tgt_h <= i_cfg_data[TGT_W-1:0];
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                CFG_SIGMA: r_sigma <= i_cfg_data[SIGMA_W-1:0];
                default: ;
            endcase
        end
    end

    // sanitized sizes
    logic [TWW-1:0]     tw_c, tw_m1;
    logic [THW-1:0]     th_c, th_m1;
    logic [SRC_W-1:0]   sw_c, sh_c;
    logic [SIGMA_W-1:0] sg;

    always_comb begin
        if (r_tgt_w == '0) tw_c = TWW'(1);
        else if (int'(r_tgt_w) > MAX_WIDTH) tw_c = TWW'(MAX_WIDTH);
        else tw_c = TWW'(r_tgt_w);
        if (r_tgt_h == '0) th_c = THW'(1);
        else if (int'(r_tgt_h) > MAX_HEIGHT) th_c = THW'(MAX_HEIGHT);
        else th_c = THW'(r_tgt_h);
    end
    assign tw_m1 = tw_c - 1'b1;
    assign th_m1 = th_c - 1'b1;
    assign sw_c  = (r_src_w == '0) ? SRC_W'(1) : r_src_w;
    assign sh_c  = (r_src_h == '0) ? SRC_W'(1) : r_src_h;
    assign sg    = (r_sigma == '0) ? SIGMA_W'(1) : r_sigma;

    // control and datapath registers
    logic [3:0]         r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_rd_zero, n_rd_zero;
    logic               r_out_valid, n_out_valid;
    logic [PIX_W-1:0]   r_out_pix, n_out_pix;
    logic [COORD_W-1:0] r_px, r_py;
    logic [SX_W-1:0]    r_sx, r_sy;
    logic [XW-1:0]      r_x0, r_x1, r_x, n_x;
    logic [YW-1:0]      r_y1, r_y, n_y;
    logic [DEN_W-1:0]   r_den;
    logic [2*DX_W-1:0]  r_dx2, r_dy2;

    // shared divider
    t_div_stat          div_stat;
    logic               div_start;
    logic [NW-1:0]      div_num, div_quo;
    logic [DEN_W-1:0]   div_den;

    // scaling operands: x and y share one multiplier
    logic               sel_x;
    logic [COORD_W-1:0] p_sel;
    logic [CW-1:0]      t_sel;
    logic [SRC_W-1:0]   s_sel;
    logic [COORD_W+CW-1:0] prod_s;
    logic [NW-1:0]      num_s;

    assign sel_x  = (r_state == S_SCX);
    assign p_sel  = sel_x ? r_px : r_py;
    assign t_sel  = sel_x ? CW'(tw_c) : CW'(th_c);
    assign s_sel  = sel_x ? sw_c : sh_c;
    assign prod_s = p_sel * t_sel;
    assign num_s  = NW'({prod_s, 4'b0000}) + NW'(s_sel[SRC_W-1:1]);

    // table index numerator
    logic [SUM_W-1:0]   sum_d;
    logic [INUM_W-1:0]  prod_i;
    logic [NW-1:0]      num_i;

    assign sum_d  = SUM_W'(r_dx2) + SUM_W'(r_dy2);
    assign prod_i = INUM_W'(sum_d) * INUM_W'(EXP_TABLE_DEPTH);
    assign num_i  = NW'(prod_i) + NW'(r_den[DEN_W-1:1]);

    assign div_start = (r_state == S_SCX) || (r_state == S_SCY) || (r_state == S_PIX_B);
    assign div_num   = (r_state == S_PIX_B) ? num_i : num_s;
    assign div_den   = (r_state == S_PIX_B) ? r_den : DEN_W'(s_sel);

    phr_div #(
        .NUM_W (NW),
        .D_W   (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // window bounds
    logic [DX_W-1:0]    ext8;
    logic [15:0]        sg_sq;
    logic [SS_W-1:0]    hs_x, hs_y;
    logic [LO_W-1:0]    lo_x, lo_y;
    logic [HI_W-1:0]    hr_x, hr_y;
    logic [XW-1:0]      hi_x;
    logic [YW-1:0]      hi_y;
    logic               win_empty;

    assign ext8  = sg * 6'd48;
    assign sg_sq = sg * sg;
    assign hs_x  = SS_W'(r_sx) + SS_W'(ext8) + SS_W'(255);
    assign hs_y  = SS_W'(r_sy) + SS_W'(ext8) + SS_W'(255);
    assign hr_x  = hs_x[SS_W-1:8];
    assign hr_y  = hs_y[SS_W-1:8];
    assign hi_x  = (hr_x > HI_W'(tw_m1)) ? XW'(tw_m1) : XW'(hr_x);
    assign hi_y  = (hr_y > HI_W'(th_m1)) ? YW'(th_m1) : YW'(hr_y);

    always_comb begin
        logic [SX_W-1:0] dlo_x;
        logic [SX_W-1:0] dlo_y;
        dlo_x = r_sx - SX_W'(ext8);
        dlo_y = r_sy - SX_W'(ext8);
        lo_x = (r_sx < SX_W'(ext8)) ? '0 : dlo_x[SX_W-1:8];
        lo_y = (r_sy < SX_W'(ext8)) ? '0 : dlo_y[SX_W-1:8];
    end
    assign win_empty = (lo_x > LO_W'(hi_x)) || (lo_y > LO_W'(hi_y));

    // binary pixel
    logic [SS_W-1:0]    bs_x, bs_y;
    logic [XW-1:0]      bx;
    logic [YW-1:0]      by;

    assign bs_x = SS_W'(r_sx) + SS_W'(128);
    assign bs_y = SS_W'(r_sy) + SS_W'(128);
    assign bx   = (bs_x[SS_W-1:8] > HI_W'(tw_m1)) ? XW'(tw_m1) : XW'(bs_x[SS_W-1:8]);
    assign by   = (bs_y[SS_W-1:8] > HI_W'(th_m1)) ? YW'(th_m1) : YW'(bs_y[SS_W-1:8]);

    // distances of the current pixel
    logic [SX_W-1:0]    xs, ys, dxf, dyf;
    logic [DX_W-1:0]    dx, dy;
    logic [2*DX_W-1:0]  dx_sq, dy_sq;

    assign xs    = SX_W'({r_x, 8'h00});
    assign ys    = SX_W'({r_y, 8'h00});
    assign dxf   = (r_sx > xs) ? r_sx - xs : xs - r_sx;
    assign dyf   = (r_sy > ys) ? r_sy - ys : ys - r_sy;
    assign dx    = dxf[DX_W-1:0];
    assign dy    = dyf[DX_W-1:0];
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    // store addresses
    logic [AW-1:0]      pix_addr, bin_addr, rd_addr;
    logic               rd_ok;

    assign pix_addr = AW'(AW'(r_y) * AW'(MAX_WIDTH)) + AW'(r_x);
    assign bin_addr = AW'(AW'(by) * AW'(MAX_WIDTH)) + AW'(bx);
    assign rd_addr  = AW'(AW'(i_read_row) * AW'(MAX_WIDTH)) + AW'(i_read_col);
    assign rd_ok    = (int'(i_read_row) < MAX_HEIGHT) && (int'(i_read_col) < MAX_WIDTH);

    // exp table
    logic               exp_busy;
    logic               exp_re;
    logic [PIX_W-1:0]   exp_rdata;

    assign exp_re = (r_state == S_PIX_W) && div_stat.done
                    && (div_quo < NW'(EXP_TABLE_DEPTH));

    phr_exp #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (exp_busy),
        .i_re    (exp_re),
        .i_raddr (div_quo[ELW-1:0]),
        .o_rdata (exp_rdata)
    );

    // heat store ports
    logic               accept;
    logic               heat_we, heat_re;
    logic [AW-1:0]      heat_waddr, heat_raddr;
    logic [PIX_W-1:0]   heat_wdata, heat_rdata;

    assign o_ready = (r_state == S_IDLE) && !exp_busy;
    assign accept  = i_valid && o_ready;
    assign heat_re = (accept && i_op == OP_READ && rd_ok) || (r_state == S_PIX_A);
    assign heat_raddr = (r_state == S_PIX_A) ? pix_addr : rd_addr;

    always_comb begin
        heat_we    = 1'b0;
        heat_waddr = pix_addr;
        heat_wdata = exp_rdata;
        unique case (r_state)
            S_CLEAR: begin
                heat_we    = 1'b1;
                heat_waddr = r_clr;
                heat_wdata = '0;
            end
            S_BIN: begin
                heat_we    = 1'b1;
                heat_waddr = bin_addr;
                heat_wdata = '1;
            end
            S_PIX_C: heat_we = exp_rdata > heat_rdata;
            default: ;
        endcase
    end

    phr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_D)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (heat_we),
        .i_waddr (heat_waddr),
        .i_wdata (heat_wdata),
        .i_re    (heat_re),
        .i_raddr (heat_raddr),
        .o_rdata (heat_rdata)
    );

    // sequencer
    logic last_px;
    logic out_free;

    assign last_px  = (r_x == r_x1) && (r_y == r_y1);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_rd_zero   = r_rd_zero;
        n_x         = r_x;
        n_y         = r_y;
        n_out_valid = r_out_valid && !i_ready;
        n_out_pix   = r_out_pix;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(STORE_D - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_PLACE: n_state = S_SCX;
                        OP_READ: begin
                            n_rd_zero = !rd_ok;
                            n_state   = S_RD;
                        end
                        OP_CLEAR: begin
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_rd_zero ? '0 : heat_rdata;
                    n_state     = S_IDLE;
                end
            end
            S_SCX:   n_state = S_SCX_W;
            S_SCX_W: if (div_stat.done) n_state = S_SCY;
            S_SCY:   n_state = S_SCY_W;
            S_SCY_W: if (div_stat.done) n_state = r_mode ? S_WIN : S_BIN;
            S_BIN:   n_state = S_IDLE;
            S_WIN: begin
                n_x     = XW'(lo_x);
                n_y     = YW'(lo_y);
                n_state = win_empty ? S_IDLE : S_PIX_A;
            end
            S_PIX_A: n_state = S_PIX_B;
            S_PIX_B: n_state = S_PIX_W;
            S_PIX_W, S_PIX_C: begin
                if (r_state == S_PIX_C || (div_stat.done && !exp_re)) begin
                    // advance across the window, row by row
                    if (last_px) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_PIX_A;
                        if (r_x == r_x1) begin
                            n_x = r_x0;
                            n_y = r_y + 1'b1;
                        end else begin
                            n_x = r_x + 1'b1;
                        end
                    end
                end else if (div_stat.done) begin
                    n_state = S_PIX_C;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rd_zero   <= 1'b0;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_rd_zero   <= n_rd_zero;
            r_out_valid <= n_out_valid;
            r_x         <= n_x;
            r_y         <= n_y;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_pix <= n_out_pix;
        if (accept) begin
            r_px <= i_point_x_q4;
            r_py <= i_point_y_q4;
        end
        if (r_state == S_SCX_W && div_stat.done) r_sx <= div_quo[SX_W-1:0];
        if (r_state == S_SCY_W && div_stat.done) r_sy <= div_quo[SX_W-1:0];
        if (r_state == S_WIN) begin
            r_x0  <= XW'(lo_x);
            r_x1  <= hi_x;
            r_y1  <= hi_y;
            r_den <= {sg_sq, 13'd0};
        end
        if (r_state == S_PIX_A) begin
            r_dx2 <= dx_sq;
            r_dy2 <= dy_sq;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_out_pix;

`ifndef SYNTHESIS
    // clearing pass writes zero every cycle
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (heat_we && heat_wdata == '0))
        else $error("clear pass not writing zero");

    // no beat taken while the exp table fills
    a_exp_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exp_busy |-> !o_ready)
        else $error("ready during exp table fill");

    // divider is started only when free
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // splat only raises stored heat
    a_splat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIX_C && heat_we) |-> (exp_rdata > heat_rdata))
        else $error("splat lowered a pixel");

    // a finished read shows up on the output
    a_read_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD && out_free) |=> o_valid)
        else $error("read result lost");
`endif

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// point heatmap rasterizer testbench
// Drives place, read, clear and unknown beats under changing register
// settings, predicts every pixel read from its own copy of the heat store
// and compares each result beat against the oldest predicted value.
// ----------------------------------------------------------------------------
module testbench;
    import phr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_H     = MAX_HEIGHT_DEF;
    localparam int GRID_W     = MAX_WIDTH_DEF;
    localparam int LUT_DEPTH  = EXP_TABLE_DEPTH_DEF;
    localparam int STALL_MAX  = 200000;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // heat store predictor and pending pixel values
    class heat_scoreboard;
        bit [15:0] heat_store [GRID_H*GRID_W];
        bit [15:0] exp_lut [LUT_DEPTH];
        longint unsigned src_w, src_h, tgt_w, tgt_h, mode, sigma;
        bit [15:0] pixel_q [$];
        int unsigned errors;

        function new();
            longint unsigned step, term, ratio, cur, v;
            src_w = 256; src_h = 256; tgt_w = 256; tgt_h = 256;
            mode = 0; sigma = 32;
            errors = 0;
            foreach (heat_store[i]) heat_store[i] = '0;
            // exp(-16/depth) in Q0.32, then a power series of it
            step  = (longint'(16) << 32) / LUT_DEPTH;
            term  = longint'(1) << 32;
            ratio = term;
            for (int n = 1; n < 64; n++) begin
                if (term != 0) begin
                    term = ((term * step) >> 32) / n;
                    if (n % 2 == 1) ratio = ratio - term;
                    else ratio = ratio + term;
                end
            end
            cur = longint'(1) << 32;
            for (int i = 0; i < LUT_DEPTH; i++) begin
                v = (cur + 32768) >> 16;
                exp_lut[i] = (v > 65535) ? 16'hFFFF : v[15:0];
                cur = (cur * ratio) >> 32;
            end
        endfunction

        function void write_reg(bit [2:0] idx, bit [12:0] val);
            case (idx)
                CFG_SRC_W: src_w = val;
                CFG_SRC_H: src_h = val;
                CFG_TGT_W: tgt_w = val[8:0];
                CFG_TGT_H: tgt_h = val[8:0];
                CFG_MODE:  mode  = val[0];
                CFG_SIGMA: sigma = val[7:0];
                default: ;
            endcase
        endfunction

        function longint unsigned fit_dim(longint unsigned v, longint unsigned maxv);
            if (v == 0) return 1;
            return (v > maxv) ? maxv : v;
        endfunction

        function longint unsigned scale(longint unsigned p, longint unsigned t,
                                        longint unsigned s);
            longint unsigned sd;
            sd = (s == 0) ? 1 : s;
            return (p * 16 * t + sd / 2) / sd;
        endfunction

        function void place(longint unsigned px, longint unsigned py);
            longint unsigned tw, th, sx, sy, c, r, sg, ext, den;
            longint unsigned x0, x1, y0, y1, dx, dy, idx, h;
            bit [15:0] v;
            tw = fit_dim(tgt_w, GRID_W);
            th = fit_dim(tgt_h, GRID_H);
            sx = scale(px, tw, src_w);
            sy = scale(py, th, src_h);
            if (mode == 0) begin
                c = (sx + 128) >> 8;
                r = (sy + 128) >> 8;
                if (c > tw - 1) c = tw - 1;
                if (r > th - 1) r = th - 1;
                heat_store[r * GRID_W + c] = 16'hFFFF;
            end else begin
                sg  = (sigma == 0) ? 1 : sigma;
                ext = 3 * sg * 16;
                den = 32 * (sg * 16) * (sg * 16);
                // window of three sigma, clipped to the grid
                h  = (sx + ext + 255) >> 8;
                x0 = (sx < ext) ? 0 : ((sx - ext) >> 8);
                x1 = (h > tw - 1) ? tw - 1 : h;
                h  = (sy + ext + 255) >> 8;
                y0 = (sy < ext) ? 0 : ((sy - ext) >> 8);
                y1 = (h > th - 1) ? th - 1 : h;
                for (longint unsigned y = y0; y <= y1; y++) begin
                    dy = (y * 256 > sy) ? y * 256 - sy : sy - y * 256;
                    for (longint unsigned x = x0; x <= x1; x++) begin
                        dx  = (x * 256 > sx) ? x * 256 - sx : sx - x * 256;
                        idx = ((dx * dx + dy * dy) * LUT_DEPTH + den / 2) / den;
                        v   = (idx < LUT_DEPTH) ? exp_lut[idx] : 16'd0;
                        if (v > heat_store[y * GRID_W + x]) heat_store[y * GRID_W + x] = v;
                    end
                end
            end
        endfunction

        function void note_beat(bit [1:0] op, bit [15:0] x, bit [15:0] y,
                                bit [7:0] row, bit [7:0] col);
            case (op)
                OP_PLACE: place(x, y);
                OP_READ:  pixel_q.push_back(heat_store[int'(row) * GRID_W + int'(col)]);
                OP_CLEAR: foreach (heat_store[i]) heat_store[i] = '0;
                default: ;
            endcase
        endfunction

        function void check_pixel(bit [15:0] got);
            bit [15:0] want;
            if (pixel_q.size() == 0) begin
                $error("pixel_value: result beat with none expected, actual %0d", got);
                errors++;
                return;
            end
            want = pixel_q.pop_front();
            if (got !== want) begin
                $error("pixel_value: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFGI_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_op;
    logic [COORD_W-1:0] i_point_x_q4;
    logic [COORD_W-1:0] i_point_y_q4;
    logic [7:0]         i_read_row;
    logic [7:0]         i_read_col;
    logic               o_valid;
    logic               i_ready;
    logic [PIX_W-1:0]   o_pixel_value;

    heat_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;
    int clears_left;
    int near_row, near_col;
    int unsigned cur_sw, cur_sh, cur_tw, cur_th;

    point_heatmap_rasterizer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_point_x_q4  (i_point_x_q4),
        .i_point_y_q4  (i_point_y_q4),
        .i_read_row    (i_read_row),
        .i_read_col    (i_read_col),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_value (o_pixel_value)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // result side: check beats and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_pixel(o_pixel_value);
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_beat(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                             logic [7:0] row, logic [7:0] col);
        i_valid      <= 1'b1;
        i_op         <= op;
        i_point_x_q4 <= x;
        i_point_y_q4 <= y;
        i_read_row   <= row;
        i_read_col   <= col;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_beat(op, x, y, row, col);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // a read beat orders behind all earlier work, so its result marks idle
    task automatic wait_idle();
        send_beat(OP_READ, '0, '0, 8'd0, 8'd0);
        i_valid <= 1'b0;
        while (sb.pixel_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs(int unsigned sw, int unsigned sh, int unsigned tw,
                              int unsigned th, int unsigned mode, int unsigned sigma);
        int unsigned vals [8];
        vals = '{sw, sh, tw, th, mode, sigma, 8191, 8191};
        cur_sw = (sw == 0) ? 1 : sw;
        cur_sh = (sh == 0) ? 1 : sh;
        cur_tw = (tw == 0) ? 1 : ((tw > GRID_W) ? GRID_W : tw);
        cur_th = (th == 0) ? 1 : ((th > GRID_H) ? GRID_H : th);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[2:0];
            i_cfg_data <= vals[i][12:0];
            @(posedge i_clk);
            sb.write_reg(i[2:0], vals[i][12:0]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_beat();
        int pick;
        logic [15:0] x, y;
        logic [7:0] row, col;
        pick = $urandom_range(0, 99);
        if (pick < 48) begin
            if ($urandom_range(0, 4) == 0) begin
                x = $urandom; y = $urandom;
            end else begin
                x = $urandom_range(0, cur_sw * 16 - 1);
                y = $urandom_range(0, cur_sh * 16 - 1);
            end
            near_col = (int'(x) * 16 * cur_tw / cur_sw) >> 8;
            near_row = (int'(y) * 16 * cur_th / cur_sh) >> 8;
            send_beat(OP_PLACE, x, y, $urandom, $urandom);
        end else if (pick < 93) begin
            case ($urandom_range(0, 2))
                0: begin
                    row = near_row + $urandom_range(0, 4) - 2;
                    col = near_col + $urandom_range(0, 4) - 2;
                end
                1: begin
                    row = $urandom_range(0, cur_th - 1);
                    col = $urandom_range(0, cur_tw - 1);
                end
                default: begin
                    row = $urandom; col = $urandom;
                end
            endcase
            send_beat(OP_READ, $urandom, $urandom, row, col);
        end else if (pick < 98 || clears_left == 0) begin
            send_beat(OP_UNKNOWN, $urandom, $urandom, $urandom, $urandom);
        end else begin
            clears_left--;
            send_beat(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct = 20;
        recv_idle_pct = 86;
        clears_left   = 2;
        near_row = 0; near_col = 0;
        cur_sw = 256; cur_sh = 256; cur_tw = 256; cur_th = 256;
        stall_cycles  = 0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_ready      <= 1'b0;
        i_op         <= OP_PLACE;
        i_point_x_q4 <= '0;
        i_point_y_q4 <= '0;
        i_read_row   <= '0;
        i_read_col   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // binary mode at reset settings: corners, clamping, unknown op, clear
        send_beat(OP_READ, '0, '0, 8'd0, 8'd0);
        send_beat(OP_PLACE, 16'd0, 16'd0, 8'd0, 8'd0);
        send_beat(OP_READ, '0, '0, 8'd0, 8'd0);
        send_beat(OP_PLACE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_beat(OP_READ, '0, '0, 8'hFF, 8'hFF);
        send_beat(OP_PLACE, 16'h8000, 16'h1234, 8'h00, 8'h00);
        send_beat(OP_READ, 16'hFFFF, 16'hFFFF, 8'd145, 8'd128);
        send_beat(OP_UNKNOWN, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_beat(OP_CLEAR, '0, '0, 8'd0, 8'd0);
        send_beat(OP_READ, '0, '0, 8'd0, 8'd0);
        wait_idle();

        // widest sigma on a small grid so the window clips
        write_regs(64, 64, 16, 16, 1, 255);
        send_beat(OP_PLACE, 16'd512, 16'd512, 8'd0, 8'd0);
        send_beat(OP_READ, '0, '0, 8'd8, 8'd8);
        send_beat(OP_READ, '0, '0, 8'd0, 8'd15);
        send_beat(OP_READ, '0, '0, 8'd200, 8'd200);
        wait_idle();

        // zero source and target sizes, oversized target, zero sigma
        write_regs(0, 4096, 0, 300, 1, 0);
        send_beat(OP_PLACE, 16'd8, 16'hFFFF, 8'd0, 8'd0);
        send_beat(OP_READ, '0, '0, 8'd255, 8'd0);
        send_beat(OP_READ, '0, '0, 8'd254, 8'd0);
        wait_idle();

        // widest source register value, one-row grid
        write_regs(8191, 1, 256, 1, 0, 1);
        send_beat(OP_PLACE, 16'hFFFF, 16'd0, 8'd0, 8'd0);
        send_beat(OP_READ, '0, '0, 8'd0, 8'd128);
        wait_idle();

        // random phases: receiver idles, then sender idles, then neither
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 86; recv_idle_pct = 20;
            end else if (ph == 4) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            write_regs($urandom_range(16, 512), $urandom_range(16, 512),
                       $urandom_range(8, 32), $urandom_range(8, 32),
                       $urandom_range(0, 1), $urandom_range(1, 16));
            repeat (35) random_beat();
            wait_idle();
        end

        i_valid <= 1'b0;
        while (sb.pixel_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
